/* src/fac_pkg.sv */
// Shared sizes, helpers and the cell control bundle for frame_autocorrelation.
// No dependencies.
package fac_pkg;

  localparam int MAX_FRAME   = 32;
  localparam int SAMPLE_BITS = 16;
  localparam int SUM_BITS    = 38;
  localparam int LAG_BITS    = 6;
  localparam int CFG_LEN_W   = 6;
  localparam int CFG_W       = 6;
  localparam int PROD_W      = 2 * SAMPLE_BITS;
  localparam int LEN_W       = $clog2(MAX_FRAME + 1);
  localparam int IDX_W       = $clog2(MAX_FRAME);

  localparam logic REG_FRAME_LENGTH = 1'b0;
  localparam logic REG_BINARY_MODE  = 1'b1;

  typedef struct packed {
    logic clear;
    logic bcast_vld;
    logic binary;
    logic shift;
  } fac_ctrl_t;

  function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_LEN_W-1:0] len);
    logic [LEN_W-1:0] res;
    if (len == '0) begin
      res = LEN_W'(1);
    end else if (int'(len) > MAX_FRAME) begin
      res = LEN_W'(MAX_FRAME);
    end else begin
      res = LEN_W'(len);
    end
    return res;
  endfunction

endpackage

/* src/fac_cell.sv */
// One lag cell: sample tap, registered product and lag accumulator.
// Depends on fac_pkg.
module fac_cell
  import fac_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fac_ctrl_t                     ctrl_i,
  input  logic signed [SAMPLE_BITS-1:0] bcast_i,
  input  logic signed [SAMPLE_BITS-1:0] tap_i,
  output logic signed [SAMPLE_BITS-1:0] tap_o,
  input  logic signed [SUM_BITS-1:0]    sum_i,
  output logic signed [SUM_BITS-1:0]    sum_o
);

  logic signed [SAMPLE_BITS-1:0] tap_q;
  logic signed [PROD_W-1:0]      prod_d, prod_q;
  logic signed [SUM_BITS-1:0]    acc_q;
  logic                          prod_vld_q;

  always_comb begin
    if (ctrl_i.binary) begin
      prod_d = PROD_W'(bcast_i[0] & tap_i[0]);
    end else begin
      prod_d = bcast_i * tap_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= ctrl_i.bcast_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.clear) begin
      tap_q <= '0;
      acc_q <= '0;
    end else begin
      if (ctrl_i.bcast_vld) begin
        tap_q  <= tap_i;
        prod_q <= prod_d;
      end
      if (ctrl_i.shift) begin
        acc_q <= sum_i;
      end else if (prod_vld_q) begin
        acc_q <= acc_q + SUM_BITS'(prod_q);
      end
    end
  end

  assign tap_o = tap_q;
  assign sum_o = acc_q;

endmodule

/* src/frame_autocorrelation_top.sv */
// Sequence: a frame's last sample starts a compute pass (COMP, then FLUSH),
// then one result per cycle while out_stall_i is low (L results); L is the
// effective frame length. Loading: one sample per cycle; in_stall_o holds off
// the next frame until the last result of this frame is loaded.
// Reset: frame_length 32, binary_mode 0, empty frame, no result pending.
module frame_autocorrelation_top
  import fac_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [CFG_W-1:0]              cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [LAG_BITS-1:0]           lag_index_o,
  output logic signed [SUM_BITS-1:0]    corr_sum_o,
  output logic                          last_lag_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_COMP  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [CFG_LEN_W-1:0]   frame_length_q;
  logic                   binary_mode_q;
  logic [LEN_W-1:0]       len_eff;
  logic [LEN_W-1:0]       load_cnt_q, load_cnt_d, load_next;
  logic [LEN_W-1:0]       step_q, step_d;
  logic [IDX_W-1:0]       slot;
  logic                   in_fire, frame_done, out_load;
  logic                   rd_vld_q;

  logic signed [SAMPLE_BITS-1:0] frame_store [MAX_FRAME];
  logic signed [SAMPLE_BITS-1:0] rd_data_q;

  logic                   out_vld_q;
  logic [LAG_BITS-1:0]    lag_q;
  logic signed [SUM_BITS-1:0] sum_q;
  logic                   last_q;

  fac_ctrl_t                     ctrl;
  logic signed [SAMPLE_BITS-1:0] tap_in  [MAX_FRAME];
  logic signed [SAMPLE_BITS-1:0] tap_out [MAX_FRAME];
  logic signed [SUM_BITS-1:0]    sum_w   [MAX_FRAME+1];

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_length_q <= CFG_LEN_W'(32);
      binary_mode_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_LENGTH: frame_length_q <= cfg_wdata_i[CFG_LEN_W-1:0];
        REG_BINARY_MODE:  binary_mode_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign len_eff    = eff_len(frame_length_q);
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign slot       = load_cnt_q[IDX_W-1:0];
  assign load_next  = LEN_W'(slot) + LEN_W'(1);
  assign frame_done = (load_next >= len_eff);
  assign out_load   = (state_q == ST_DRAIN) && (!out_vld_q || !out_stall_i);

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    load_cnt_d = load_cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (frame_done) begin
            load_cnt_d = '0;
            step_d     = '0;
            state_d    = ST_COMP;
          end else begin
            load_cnt_d = load_next;
          end
        end
      end
      ST_COMP: begin
        if (step_q == len_eff - LEN_W'(1)) begin
          step_d  = '0;
          state_d = ST_FLUSH;
        end else begin
          step_d = step_q + LEN_W'(1);
        end
      end
      ST_FLUSH: begin
        if (step_q == LEN_W'(1)) begin
          step_d  = '0;
          state_d = ST_DRAIN;
        end else begin
          step_d = step_q + LEN_W'(1);
        end
      end
      ST_DRAIN: begin
        if (out_load) begin
          step_d = step_q + LEN_W'(1);
          if (step_q == len_eff - LEN_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      step_q     <= '0;
      load_cnt_q <= '0;
      rd_vld_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      step_q     <= step_d;
      load_cnt_q <= load_cnt_d;
      rd_vld_q   <= (state_q == ST_COMP);
    end
  end

  // frame store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      frame_store[slot] <= sample_i;
    end
    rd_data_q <= frame_store[step_q[IDX_W-1:0]];
  end

  // lag chain
  always_comb begin
    ctrl.clear     = in_fire && frame_done;
    ctrl.bcast_vld = rd_vld_q;
    ctrl.binary    = binary_mode_q;
    ctrl.shift     = out_load;
  end

  assign sum_w[MAX_FRAME] = '0;

  for (genvar k = 0; k < MAX_FRAME; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign tap_in[k] = rd_data_q;
    end else begin : g_body
      assign tap_in[k] = tap_out[k-1];
    end
    fac_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .bcast_i (rd_data_q),
      .tap_i   (tap_in[k]),
      .tap_o   (tap_out[k]),
      .sum_i   (sum_w[k+1]),
      .sum_o   (sum_w[k])
    );
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      lag_q  <= LAG_BITS'(step_q);
      sum_q  <= sum_w[0];
      last_q <= (step_q == len_eff - LEN_W'(1));
    end
  end

  assign out_valid_o = out_vld_q;
  assign lag_index_o = lag_q;
  assign corr_sum_o  = sum_q;
  assign last_lag_o  = last_q;

  a_load_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(load_cnt_q) < MAX_FRAME)
    else $error("load count out of range");

  a_out_from_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q) == ST_DRAIN)
    else $error("result raised outside drain");

  a_read_from_comp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(state_q) == ST_COMP)
    else $error("broadcast outside compute pass");

  a_drain_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN && !out_vld_q) |=> out_vld_q)
    else $error("drain did not load result register");

endmodule
